// File: rtl/sigma_band_event_detector_core_defines.svh
// ----------------------------------------------------------------------------
// Sigma band event detector assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SIGMA_BAND_EVENT_DETECTOR_CORE_DEFINES_SVH
`define SIGMA_BAND_EVENT_DETECTOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define SBED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle
`define SBED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbed_pkg.sv
// ----------------------------------------------------------------------------
// Sigma band event detector package
// Widths, reset values and shared types of the detector.
// ----------------------------------------------------------------------------
package sbed_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 512;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned K_W            = 16;
  localparam logic [K_W-1:0] K_RESET     = 16'd1280;  // 5.0 in Q8.8
  localparam int unsigned VAR_W          = 48;         // variance, Q.16
  localparam int unsigned SIG_W          = VAR_W / 2;  // sigma, Q.8
  localparam int unsigned HW_W           = 32;         // halfwidth, Q24.8

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sbed_sqrt_stat_t;

endpackage

// File: rtl/sbed_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one signed ADC sample per word.
// ----------------------------------------------------------------------------
interface sbed_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/sbed_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the event flags and band centre per word.
// ----------------------------------------------------------------------------
interface sbed_out_if;
  logic               valid;
  logic               ready;
  logic               event_start;
  logic               event_stop;
  logic               in_event;
  logic               baseline_ready;
  logic signed [15:0] baseline_mean;

  modport source (output valid, output event_start, output event_stop, output in_event,
                  output baseline_ready, output baseline_mean, input ready);
  modport sink   (input valid, input event_start, input event_stop, input in_event,
                  input baseline_ready, input baseline_mean, output ready);
endinterface

// File: rtl/sbed_ring.sv
// ----------------------------------------------------------------------------
// Sample ring memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbed_ring #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr_i,
  input  logic signed [sbed_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr_i,
  output logic signed [sbed_pkg::SAMPLE_W-1:0] rd_data_o
);
  import sbed_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: rtl/sbed_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit root, one result bit per cycle, floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module sbed_isqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sbed_pkg::VAR_W-1:0]       rad_i,
  output logic [sbed_pkg::SIG_W-1:0]       root_o,
  output sbed_pkg::sbed_sqrt_stat_t        stat_o
);
  import sbed_pkg::*;

  localparam int unsigned CNT_W = $clog2(SIG_W + 1);

  logic [VAR_W-1:0] rad_q, rad_d;
  logic [SIG_W+1:0] rem_q, rem_d;
  logic [SIG_W-1:0] root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SIG_W+2:0] rem_sh, trial;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q[SIG_W:0], rad_q[VAR_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(SIG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[VAR_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = (SIG_W+2)'(rem_sh - trial);
        root_d = {root_q[SIG_W-2:0], 1'b1};
      end else begin
        rem_d  = (SIG_W+2)'(rem_sh);
        root_d = {root_q[SIG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/sigma_band_event_detector_core.sv
// ----------------------------------------------------------------------------
// Sigma band event detector core
// Mean +/- k*sigma event detection over a ring of the last WINDOW_LEN samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one signed sample per word; out_o returns one result word per
//   sample (start/stop flags, event state, baseline ready, band centre).
//   cfg_we_i/cfg_wdata_i write k (Q8.8); write only while the block is idle.
//   WINDOW_LEN must be a power of two (4 to 4096).
// Sequence:
//   A plain sample passes evaluate, ring write and sum update, and output
//   load, and is then valid on out_o; the next sample is accepted only once
//   the block has returned to idle.
//   A sample that sets a band (end of the first fill, or a sample leaving
//   the band outside an event) also passes the square, difference, root and
//   scale steps (the latter kind then a band check) before its result, and
//   waits in the root step for the bit-serial square root to find sigma.
//   One sample is in flight at a time; in_i.ready is high while idle.
// Reset: all sums, the fill count, the band and the event state clear;
//   k returns to 5.0. The ring needs no clearing: it is filled before use.
// Stall: a finished result waits in the output register; a new sample may be
//   accepted meanwhile, and its result waits until that register frees.
// ----------------------------------------------------------------------------
`include "sigma_band_event_detector_core_defines.svh"

module sigma_band_event_detector_core #(
  parameter int unsigned WINDOW_LEN = sbed_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbed_pkg::K_W-1:0]   cfg_wdata_i,
  sbed_in_if.sink                    in_i,
  sbed_out_if.source                 out_o
);
  import sbed_pkg::*;

  localparam int unsigned LOG2N = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = LOG2N + 1;
  localparam int unsigned SUM_W = SAMPLE_W + 1 + LOG2N;
  localparam int unsigned MAG_W = SAMPLE_W + LOG2N;
  localparam int unsigned SQ_W = 2 * SAMPLE_W - 1;
  localparam int unsigned SQS_W = SQ_W + LOG2N;
  localparam int unsigned D_W = SQS_W + LOG2N;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_PUSH, S_SQR, S_DIFF, S_ROOT, S_SCALE, S_CHECK, S_OUT
  } state_e;

  state_e                      state_q;
  logic [K_W-1:0]              k_q;
  logic [LOG2N-1:0]            wp_q;
  logic [FILL_W-1:0]           fill_q;
  logic signed [SUM_W-1:0]     sum_q;
  logic [SQS_W-1:0]            sqs_q;
  logic signed [SAMPLE_W-1:0]  center_q;
  logic [HW_W-1:0]             hw_q;
  logic                        active_q;
  logic signed [SAMPLE_W-1:0]  s_q;
  logic signed [SAMPLE_W-1:0]  old_q;
  logic [SQ_W-1:0]             sq_new_q, sq_old_q;
  logic [D_W-1:0]              mag_sq_q;
  logic                        band_fill_q;
  logic                        start_q, stop_q;
  logic                        out_v_q;
  logic                        o_start_q, o_stop_q, o_in_q, o_rdy_q;
  logic signed [SAMPLE_W-1:0]  o_mean_q;

  logic                        accept;
  logic                        filling;
  logic signed [SAMPLE_W-1:0]  rd_data;
  logic signed [SAMPLE_W-1:0]  old_w;
  logic signed [SAMPLE_W+18:0] x_w, c_w, h_w;
  logic                        outside;
  logic [MAG_W-1:0]            mag_w;
  logic [D_W-1:0]              nq_w, d_w;
  logic [VAR_W-1:0]            vx_w;
  logic [SIG_W-1:0]            sigma;
  sbed_sqrt_stat_t             sq_stat;
  logic [K_W+SIG_W-1:0]        khw_w;
  logic                        out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign filling  = fill_q < FILL_W'(WINDOW_LEN);
  assign out_free = !out_v_q || out_o.ready;

  // ring of past samples
  sbed_ring #(.DEPTH(WINDOW_LEN)) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == S_PUSH),
    .wr_addr_i (wp_q),
    .wr_data_i (s_q),
    .rd_en_i   (accept),
    .rd_addr_i (wp_q),
    .rd_data_o (rd_data)
  );

  // band test: 256*s against 256*centre +/- halfwidth
  always_comb begin
    x_w     = {{11{s_q[SAMPLE_W-1]}}, s_q, 8'd0};
    c_w     = {{11{center_q[SAMPLE_W-1]}}, center_q, 8'd0};
    h_w     = {3'd0, hw_q};
    outside = (x_w > c_w + h_w) || (x_w < c_w - h_w);
  end

  // variance path: D = N*Q - S^2, var = D * 2^16 / N^2
  always_comb begin
    old_w = filling ? '0 : rd_data;
    mag_w = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
    nq_w  = {sqs_q, {LOG2N{1'b0}}};
    d_w   = (nq_w > mag_sq_q) ? nq_w - mag_sq_q : '0;
    vx_w  = VAR_W'({d_w, 16'd0} >> (2 * LOG2N));
    khw_w = k_q * sigma;
  end

  sbed_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIFF),
    .rad_i   (vx_w),
    .root_o  (sigma),
    .stat_o  (sq_stat)
  );

  // sequencer and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= K_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sqs_q       <= '0;
      center_q    <= '0;
      hw_q        <= '0;
      active_q    <= 1'b0;
      band_fill_q <= 1'b0;
      start_q     <= 1'b0;
      stop_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      // result register: held until taken, set when a word is loaded
      out_v_q <= (out_v_q && !out_o.ready) || ((state_q == S_OUT) && out_free);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            start_q <= 1'b0;
            stop_q  <= 1'b0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (filling) begin
            band_fill_q <= 1'b1;
            state_q     <= S_PUSH;
          end else if (!active_q && outside) begin
            band_fill_q <= 1'b0;
            state_q     <= S_SQR;
          end else begin
            if (active_q && !outside) begin
              stop_q   <= 1'b1;
              active_q <= 1'b0;
            end
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          sum_q <= sum_q + SUM_W'(s_q) - SUM_W'(old_q);
          sqs_q <= sqs_q + SQS_W'(sq_new_q) - SQS_W'(sq_old_q);
          wp_q  <= wp_q + 1'b1;
          if (filling) begin
            fill_q <= fill_q + 1'b1;
          end
          if (filling && (fill_q == FILL_W'(WINDOW_LEN - 1))) begin
            state_q <= S_SQR;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_SQR:   state_q <= S_DIFF;
        S_DIFF:  state_q <= S_ROOT;
        S_ROOT: begin
          if (sq_stat.done) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          hw_q     <= khw_w[K_W+SIG_W-1 -: HW_W];
          center_q <= SAMPLE_W'(sum_q >>> LOG2N);
          state_q  <= band_fill_q ? S_OUT : S_CHECK;
        end
        S_CHECK: begin
          if (outside) begin
            start_q  <= 1'b1;
            active_q <= 1'b1;
          end
          state_q <= S_PUSH;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= in_i.sample;
    end
    if (state_q == S_EVAL) begin
      old_q    <= old_w;
      sq_new_q <= SQ_W'(s_q * s_q);
      sq_old_q <= SQ_W'(old_w * old_w);
    end
    if (state_q == S_SQR) begin
      mag_sq_q <= D_W'(mag_w * mag_w);
    end
    if (state_q == S_OUT && out_free) begin
      o_start_q <= start_q;
      o_stop_q  <= stop_q;
      o_in_q    <= active_q;
      o_rdy_q   <= !filling;
      o_mean_q  <= center_q;
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_v_q;
  assign out_o.event_start    = o_start_q;
  assign out_o.event_stop     = o_stop_q;
  assign out_o.in_event       = o_in_q;
  assign out_o.baseline_ready = o_rdy_q;
  assign out_o.baseline_mean  = o_mean_q;

  // checks
  `SBED_ASSERT(a_fill_bound, fill_q <= FILL_W'(WINDOW_LEN), "fill count beyond window")
  `SBED_ASSERT_IMP(a_no_event_fill, filling, !active_q, "event active while filling")
  `SBED_ASSERT_IMP(a_start_stop, (state_q == S_OUT), !(start_q && stop_q), "start and stop")
  `SBED_ASSERT_IMP(a_root_wait, (state_q == S_ROOT) && !sq_stat.done, sq_stat.busy,
                   "square root idle while waited on")

endmodule
